// ===== hdl/root_counter_timer_unit_macros.svh =====
// Assertion macros shared by the root counter timer unit
`ifndef ROOT_COUNTER_TIMER_UNIT_MACROS_SVH
`define ROOT_COUNTER_TIMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RCU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcu same-cycle check failed");
`define RCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcu next-cycle check failed");
`else
`define RCU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RCU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/rcu_pkg.sv =====
// Types and constants of the root counter timer unit
package rcu_pkg;

    localparam int RCU_ELAPSED_BITS = 64;
    localparam int RCU_SUM_W        = 64;
    localparam int RCU_DIV_STEP     = 4;
    localparam int RCU_DIV_DIGITS   = RCU_SUM_W / RCU_DIV_STEP;
    localparam int RCU_DIGIT_W      = $clog2(RCU_DIV_DIGITS);
    localparam int RCU_QUEUE_DEPTH  = 4;
    localparam int RCU_PTR_W        = $clog2(RCU_QUEUE_DEPTH);
    localparam int RCU_CNT_W        = RCU_PTR_W + 1;

    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;

    localparam logic [1:0] SEL_VALUE  = 2'd0;
    localparam logic [1:0] SEL_MODE   = 2'd1;
    localparam logic [1:0] SEL_TARGET = 2'd2;

    typedef enum logic [2:0] {
        K_ADVANCE,
        K_VALUE,
        K_MODE,
        K_TARGET,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hdl/rcu_front.sv =====
// Front stage: accept requests and classify them into commands
module rcu_front
    import rcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_tick_count,
    input  logic [3:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_push;
    logic w_accept;

    assign w_push     = r_valid && !i_q_status.full;
    assign o_in_stall = r_valid && i_q_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_cmd.data = i_write_data;
        unique case (i_op)
            OP_ADVANCE: begin
                n_cmd.kind = K_ADVANCE;
                n_cmd.data = i_tick_count;
            end
            OP_WRITE: begin
                unique case (i_reg_offset[3:2])
                    SEL_VALUE:  n_cmd.kind = K_VALUE;
                    SEL_MODE:   n_cmd.kind = K_MODE;
                    SEL_TARGET: n_cmd.kind = K_TARGET;
                    default:    n_cmd.kind = K_READ;
                endcase
            end
            default: n_cmd.kind = K_READ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push = w_push;
    assign o_cmd  = r_cmd;

endmodule

// ===== hdl/rcu_queue.sv =====
// Command queue between front and back
module rcu_queue
    import rcu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd                 r_mem [RCU_QUEUE_DEPTH];
    logic [RCU_PTR_W-1:0] r_wr_ptr;
    logic [RCU_PTR_W-1:0] r_rd_ptr;
    logic [RCU_CNT_W-1:0] r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_status.full  = (r_count == RCU_CNT_W'(RCU_QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd = r_mem[r_rd_ptr];

endmodule

// ===== hdl/rcu_back.sv =====
// Back end: timer state, counter reading, iterative modulo and result register
`include "root_counter_timer_unit_macros.svh"
module rcu_back
    import rcu_pkg::*;
#(
    parameter int ELAPSED_BITS = RCU_ELAPSED_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_counter_value
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [15:0]             r_base;
    logic [9:0]              r_mode;
    logic [15:0]             r_target;
    logic [RCU_SUM_W-1:0]    r_sum;
    logic [15:0]             r_rem;
    logic [15:0]             r_period;
    logic [RCU_DIGIT_W-1:0]  r_digit;
    logic [15:0]             r_result;
    logic                    r_out_valid;
    logic [15:0]             r_out_value;

    logic                    w_pop;
    logic                    w_held;
    logic [RCU_SUM_W-1:0]    w_scaled;
    logic [RCU_SUM_W-1:0]    w_sum;
    logic [15:0]             w_period;
    logic [15:0]             n_rem;
    logic                    w_load;

    assign w_pop  = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_pop  = w_pop;
    assign w_held = r_mode[0] && ((r_mode[2:1] == 2'd0) || (r_mode[2:1] == 2'd3));
    assign w_scaled = r_mode[9] ? RCU_SUM_W'(r_elapsed >> 3) : RCU_SUM_W'(r_elapsed);
    assign w_sum    = RCU_SUM_W'(r_base) + w_scaled;
    assign w_period = (r_target > 16'd1) ? r_target : 16'd1;
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        logic [16:0] t_val;
        n_rem = r_rem;
        for (int i = 0; i < RCU_DIV_STEP; i++) begin
            t_val = {n_rem, r_sum[RCU_SUM_W-1-i]};
            if (t_val >= {1'b0, r_period}) begin
                t_val = t_val - {1'b0, r_period};
            end
            n_rem = t_val[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elapsed <= '0;
            r_base    <= '0;
            r_mode    <= '0;
            r_target  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        unique case (i_cmd.kind)
                            K_ADVANCE: r_elapsed <= r_elapsed + ELAPSED_BITS'(i_cmd.data);
                            K_VALUE: begin
                                r_base    <= i_cmd.data[15:0];
                                r_elapsed <= '0;
                            end
                            K_MODE: begin
                                r_mode    <= i_cmd.data[9:0];
                                r_base    <= '0;
                                r_elapsed <= '0;
                            end
                            K_TARGET: r_target <= i_cmd.data[15:0];
                            default: ;
                        endcase
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_held || !r_mode[3]) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_digit == RCU_DIGIT_W'(RCU_DIV_DIGITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CALC: begin
                r_sum    <= w_sum;
                r_rem    <= '0;
                r_digit  <= '0;
                r_period <= w_period;
                r_result <= w_held ? r_base : w_sum[15:0];
            end
            S_DIV: begin
                r_rem   <= n_rem;
                r_sum   <= r_sum << RCU_DIV_STEP;
                r_digit <= r_digit + 1'b1;
                if (r_digit == RCU_DIGIT_W'(RCU_DIV_DIGITS - 1)) begin
                    r_result <= n_rem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= r_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_counter_value = r_out_value;

    `RCU_ASSERT_SAME(a_rem_below_period, i_clk, i_rst_n, (r_state == S_DIV), (r_rem < r_period))
    `RCU_ASSERT_NEXT(a_digit_advance, i_clk, i_rst_n, ((r_state == S_DIV) && (r_digit != RCU_DIGIT_W'(RCU_DIV_DIGITS - 1))), ((r_state == S_DIV) && (r_digit == $past(r_digit) + 1'b1)))
    `RCU_ASSERT_NEXT(a_held_reads_base, i_clk, i_rst_n, ((r_state == S_CALC) && w_held), ((r_state == S_DONE) && (r_result == r_base)))
    `RCU_ASSERT_SAME(a_pop_only_idle, i_clk, i_rst_n, w_pop, (r_state == S_IDLE))

endmodule

// ===== hdl/root_counter_timer_unit.sv =====
// Top level of the root counter timer unit
// Each request (advance time, register write or read) returns one 16-bit counter
// reading taken after the request is applied. A request is classified in the front
// stage and queued; the back end steps through idle, calc and done for it, and also
// through the divide state when reset-on-target is set (mode bit 3) and the count is
// not held, where the 64-bit sum is reduced modulo the target four bits per cycle.
// A reading passes from the front register through the queue and the back end into
// the output register. The back end handles one request at a time; a finished reading
// waits in the output register while the next request is already being worked on.
module root_counter_timer_unit
    import rcu_pkg::*;
#(
    parameter int ELAPSED_BITS = RCU_ELAPSED_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_tick_count,
    input  logic [3:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_counter_value
);

    t_q_status w_q_status;
    t_cmd      w_push_cmd;
    t_cmd      w_head_cmd;
    logic      w_push;
    logic      w_pop;

    rcu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_tick_count (i_tick_count),
        .i_reg_offset (i_reg_offset),
        .i_write_data (i_write_data),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    rcu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    rcu_back #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (w_q_status),
        .i_cmd           (w_head_cmd),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_counter_value (o_counter_value)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the root counter timer unit with random idling on both sides
`timescale 1ns / 100ps
module tb;
    import rcu_pkg::*;

    localparam int         PERIOD_NS            = 4;
    localparam int         RESET_CYCLES         = 8;
    localparam int         RANDOM_ITEMS         = 1750;
    localparam int         BURST_ITEMS          = 24;
    localparam int         HOLD_CYCLES          = 300;
    localparam int         SETTLE_CYCLES        = 64;
    localparam int         CYCLE_LIMIT          = 600000;
    localparam int         MAX_REPORTS          = 10;
    localparam int         MAX_IDLE             = 16;
    localparam logic [1:0] OP_READ              = 2'd2;
    localparam logic [1:0] OP_PEEK              = 2'd3;
    localparam logic [1:0] SEL_NONE             = 2'd3;
    localparam logic [1:0] SYNC_STOP_LO         = 2'd0;
    localparam logic [1:0] SYNC_STOP_HI         = 2'd3;
    localparam int         MODE_SYNC_EN         = 0;
    localparam int         MODE_RESET_ON_TARGET = 3;
    localparam int         MODE_DIV8            = 9;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [31:0] i_tick_count;
    logic [3:0]  i_reg_offset;
    logic [31:0] i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_counter_value;

    logic        rx_stall = 1'b0;
    logic        rx_hold  = 1'b0;
    logic        hold_go  = 1'b0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    logic [RCU_ELAPSED_BITS-1:0] timer_elapsed = '0;
    logic [15:0]                 timer_base    = '0;
    logic [9:0]                  timer_mode    = '0;
    logic [15:0]                 timer_target  = '0;

    logic [15:0] expected_counts[$];
    int          requests_sent = 0;
    int          results_seen  = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;

    assign i_out_stall = rx_stall | rx_hold;

    root_counter_timer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_tick_count   (i_tick_count),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_counter_value(o_counter_value)
    );

    always #(PERIOD_NS / 2) i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic void apply_request(input logic [1:0] op, input logic [31:0] ticks,
                                          input logic [3:0] offset, input logic [31:0] data);
        case (op)
            OP_ADVANCE: timer_elapsed = timer_elapsed + ticks;
            OP_WRITE: begin
                case (offset[3:2])
                    SEL_VALUE: begin
                        timer_base    = data[15:0];
                        timer_elapsed = '0;
                    end
                    SEL_MODE: begin
                        timer_mode    = data[9:0];
                        timer_base    = '0;
                        timer_elapsed = '0;
                    end
                    SEL_TARGET: timer_target = data[15:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] counter_reading();
        logic [1:0]  sync_sel;
        logic [63:0] scaled;
        logic [63:0] total;
        logic [63:0] period;
        sync_sel = timer_mode[2:1];
        if (timer_mode[MODE_SYNC_EN] && (sync_sel == SYNC_STOP_LO || sync_sel == SYNC_STOP_HI))
            return timer_base;
        scaled = 64'(timer_elapsed);
        if (timer_mode[MODE_DIV8])
            scaled = scaled >> 3;
        total = 64'(timer_base) + scaled;
        if (timer_mode[MODE_RESET_ON_TARGET]) begin
            period = (timer_target > 16'd1) ? 64'(timer_target) : 64'd1;
            total  = total % period;
        end
        return total[15:0];
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [31:0] ticks,
                                input logic [3:0] offset, input logic [31:0] data);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_tick_count <= ticks;
        i_reg_offset <= offset;
        i_write_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        apply_request(op, ticks, offset, data);
        expected_counts.push_back(counter_reading());
        requests_sent++;
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_counts.size() != 0);
    endtask

    task automatic send_random_request();
        int          pick;
        logic [31:0] data;
        logic [31:0] ticks;
        logic [3:0]  offset;
        pick   = $urandom_range(0, 99);
        data   = $urandom;
        offset = $urandom_range(0, 15);
        case ($urandom_range(0, 3))
            0: ticks = $urandom_range(0, 15);
            1: ticks = $urandom_range(0, 4095);
            2: ticks = $urandom_range(0, 1000000);
            default: ticks = $urandom;
        endcase
        if (pick < 35) begin
            send_request(OP_ADVANCE, ticks, offset, data);
        end else if (pick < 47) begin
            send_request(OP_WRITE, ticks, {SEL_VALUE, offset[1:0]}, data);
        end else if (pick < 57) begin
            if ($urandom_range(0, 1))
                data[MODE_RESET_ON_TARGET] = 1'b1;
            send_request(OP_WRITE, ticks, {SEL_MODE, offset[1:0]}, data);
        end else if (pick < 67) begin
            if ($urandom_range(0, 1))
                data = $urandom_range(0, 40);
            send_request(OP_WRITE, ticks, {SEL_TARGET, offset[1:0]}, data);
        end else if (pick < 72) begin
            send_request(OP_WRITE, ticks, {SEL_NONE, offset[1:0]}, data);
        end else begin
            send_request((pick < 90) ? OP_READ : OP_PEEK, ticks, offset, data);
        end
    endtask

    task automatic test_reset_reads();
        send_request(OP_READ, 32'h0, 4'h0, 32'h0);
        send_request(OP_PEEK, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
    endtask

    task automatic test_time_advance();
        send_request(OP_ADVANCE, 32'h0, 4'h0, 32'h0);
        send_request(OP_ADVANCE, 32'h1, 4'h0, 32'h0);
        send_request(OP_ADVANCE, 32'hFFFF_FFFF, 4'h0, 32'h0);
    endtask

    task automatic test_register_writes();
        send_request(OP_WRITE, 32'h0, {SEL_VALUE, 2'b11}, 32'hFFFF_FFFF);
        send_request(OP_ADVANCE, 32'h1, 4'h0, 32'h0);
        send_request(OP_WRITE, 32'h0, {SEL_NONE, 2'b00}, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 32'h0, {SEL_TARGET, 2'b01}, 32'h0000_0005);
    endtask

    task automatic test_mode_sync();
        send_request(OP_WRITE, 32'h0, {SEL_MODE, 2'b00}, {29'h0, SYNC_STOP_LO, 1'b1});
        send_request(OP_ADVANCE, 32'd50, 4'h0, 32'h0);
        send_request(OP_WRITE, 32'h0, {SEL_MODE, 2'b10}, {29'h0, SYNC_STOP_HI, 1'b1});
        send_request(OP_ADVANCE, 32'd77, 4'h0, 32'h0);
        send_request(OP_WRITE, 32'h0, {SEL_MODE, 2'b00}, {29'h0, 2'd1, 1'b1});
        send_request(OP_ADVANCE, 32'd33, 4'h0, 32'h0);
        send_request(OP_WRITE, 32'h0, {SEL_MODE, 2'b00}, 32'h0000_0200);
        send_request(OP_ADVANCE, 32'hFFFF_FFFF, 4'h0, 32'h0);
    endtask

    task automatic test_reset_on_target();
        send_request(OP_WRITE, 32'h0, {SEL_MODE, 2'b00}, 32'hFFFF_FC08);
        send_request(OP_WRITE, 32'h0, {SEL_TARGET, 2'b00}, 32'h0);
        send_request(OP_ADVANCE, 32'd1000, 4'h0, 32'h0);
        send_request(OP_WRITE, 32'h0, {SEL_TARGET, 2'b00}, 32'h1);
        send_request(OP_WRITE, 32'h0, {SEL_TARGET, 2'b00}, 32'hFFFF_FFFF);
        send_request(OP_ADVANCE, 32'hFFFF_FFFF, 4'h0, 32'h0);
        send_request(OP_WRITE, 32'h0, {SEL_MODE, 2'b00}, 32'h0000_0208);
        send_request(OP_WRITE, 32'h0, {SEL_VALUE, 2'b00}, 32'hFFFF_FFFF);
    endtask

    task automatic test_result_holdoff();
        tx_quiet = 1'b1;
        hold_go <= 1'b1;
        repeat (BURST_ITEMS) send_random_request();
        tx_quiet = 1'b0;
        drain_requests();
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 60)) begin
                send_random_request();
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                drain_requests();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin : result_sink
        int wait_cycles;
        forever begin
            wait_cycles = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (wait_cycles > 0) begin
                rx_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            rx_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid && !i_out_stall));
        end
    end

    initial begin : result_holdoff
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go <= 1'b0;
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_readings
        logic [15:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reading %h at cycle %0d", o_counter_value, cycle_count);
            end else begin
                want = expected_counts.pop_front();
                if (o_counter_value !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("counter_value mismatch on reading %0d: expected %h, got %h",
                                 results_seen, want, o_counter_value);
                end
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles with %0d readings outstanding",
                 cycle_count, expected_counts.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_READ;
        i_tick_count = '0;
        i_reg_offset = '0;
        i_write_data = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_reads();
        test_time_advance();
        test_register_writes();
        test_mode_sync();
        test_reset_on_target();
        drain_requests();
        test_result_holdoff();
        test_random_traffic(RANDOM_ITEMS);

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_counts.size() != 0) begin
            mismatches += expected_counts.size();
            $display("%0d readings never arrived", expected_counts.size());
        end
        $display("covered %0d requests: directed edge cases, a held-off output burst, random mix",
                 requests_sent);
        $display("checked %0d readings in %0d cycles, %0d mismatches",
                 results_seen, cycle_count, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
